[hw/rtl/header_length_xor_frame_parser_assert.svh]
// assertion macros shared by the parser rtl
// each macro takes a label, the clock, the active-low reset and an expression
`ifndef HEADER_LENGTH_XOR_FRAME_PARSER_ASSERT_SVH
`define HEADER_LENGTH_XOR_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define HLXFP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hlxfp assertion failed");

// condition must never be seen outside reset
`define HLXFP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hlxfp forbidden condition seen");

`else

`define HLXFP_ASSERT(lbl, clk, rst_n, prop)
`define HLXFP_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[hw/rtl/hlxfp_pkg.sv]
// ----------------------------------------------------------------------------
// hlxfp_pkg
// types and constants shared by the frame parser front, back and top level
// ----------------------------------------------------------------------------
package hlxfp_pkg;

  // sync header, token and reset timeout
  localparam logic [7:0] SYNC0         = 8'h55;
  localparam logic [7:0] SYNC1         = 8'h4E;
  localparam logic [7:0] SYNC2         = 8'h45;
  localparam logic [7:0] SYNC3         = 8'h52;
  localparam logic [7:0] TOKEN_CHAR    = 8'h3A;
  localparam logic [7:0] TIMEOUT_RESET = 8'd6;

  // checksum seed without the length byte
  localparam logic [7:0] SEED_XOR = SYNC0 ^ SYNC1 ^ SYNC2 ^ SYNC3 ^ TOKEN_CHAR;

  // input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_e;

  // parser phases
  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_HDR1    = 7'b0000010,
    PH_HDR2    = 7'b0000100,
    PH_HDR3    = 7'b0001000,
    PH_LEN     = 7'b0010000,
    PH_TOKEN   = 7'b0100000,
    PH_PAYLOAD = 7'b1000000
  } phase_e;

  // byte class flags worked out by the front
  typedef struct packed {
    logic is_sync0;
    logic is_sync1;
    logic is_sync2;
    logic is_sync3;
    logic is_token;
    logic is_zero;
  } class_t;

  // one queued item
  typedef struct packed {
    logic       opcode;
    logic [7:0] data;
    class_t     cls;
  } item_t;

  // one result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic [7:0] computed_checksum;
  } result_t;

endpackage

[hw/rtl/hlxfp_front.sv]
// ----------------------------------------------------------------------------
// hlxfp_front
// accepts input items, classifies received bytes and queues them for the back
// ----------------------------------------------------------------------------
`include "header_length_xor_frame_parser_assert.svh"

module hlxfp_front #(
  parameter int QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                opcode_i,
  input  logic [7:0]          rx_byte_i,
  output logic                item_valid_o,
  output hlxfp_pkg::item_t    item_o,
  input  logic                item_pop_i
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  hlxfp_pkg::item_t entries_q [QueueDepth];
  hlxfp_pkg::item_t in_item;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;
  logic             pop;

  // classify the incoming byte
  always_comb begin
    in_item.opcode       = opcode_i;
    in_item.data         = rx_byte_i;
    in_item.cls.is_sync0 = (rx_byte_i == hlxfp_pkg::SYNC0);
    in_item.cls.is_sync1 = (rx_byte_i == hlxfp_pkg::SYNC1);
    in_item.cls.is_sync2 = (rx_byte_i == hlxfp_pkg::SYNC2);
    in_item.cls.is_sync3 = (rx_byte_i == hlxfp_pkg::SYNC3);
    in_item.cls.is_token = (rx_byte_i == hlxfp_pkg::TOKEN_CHAR);
    in_item.cls.is_zero  = (rx_byte_i == 8'd0);
  end

  // queue handshake
  assign in_stall_o   = (count_q == CntW'(QueueDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = entries_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= in_item;
    end
  end

  `HLXFP_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(QueueDepth))
  `HLXFP_ASSERT(a_pop_needs_data, clk_i, rst_ni, item_pop_i |-> (count_q != '0))
  `HLXFP_ASSERT(a_ptrs_meet, clk_i, rst_ni,
                ((count_q == '0) || (count_q == CntW'(QueueDepth))) |-> (wr_ptr_q == rd_ptr_q))

endmodule

[hw/rtl/hlxfp_back.sv]
// ----------------------------------------------------------------------------
// hlxfp_back
// frame parser state machine, timeout countdown and output register
// ----------------------------------------------------------------------------
`include "header_length_xor_frame_parser_assert.svh"

module hlxfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          timeout_ticks_i,
  input  logic                item_valid_i,
  input  hlxfp_pkg::item_t    item_i,
  output logic                item_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hlxfp_pkg::result_t  result_o
);

  hlxfp_pkg::phase_e  phase_q, phase_d, hunt_next;
  logic [7:0]         len_q, len_d;
  logic [7:0]         left_q, left_d;
  logic [7:0]         xor_q, xor_d;
  logic [7:0]         pos_q, pos_d;
  logic [7:0]         cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  hlxfp_pkg::result_t res_q, res_d;
  logic               produces;
  logic               pop;
  logic               load;

  // a byte in the payload phase always yields a result
  assign produces   = (item_i.opcode == hlxfp_pkg::OP_BYTE) &&
                      (phase_q == hlxfp_pkg::PH_PAYLOAD);
  assign pop        = item_valid_i && (!produces || !out_valid_q || !out_stall_i);
  assign item_pop_o = pop;
  assign hunt_next  = item_i.cls.is_sync0 ? hlxfp_pkg::PH_HDR1 : hlxfp_pkg::PH_HUNT;

  // parser step
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    left_d  = left_q;
    xor_d   = xor_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    load    = 1'b0;
    if (pop) begin
      if (item_i.opcode == hlxfp_pkg::OP_TICK) begin
        // tick counts the idle timer down
        if (cnt_q != 8'd0) begin
          cnt_d = cnt_q - 8'd1;
          if (cnt_q == 8'd1) begin
            phase_d = hlxfp_pkg::PH_HUNT;
          end
        end
      end else begin
        cnt_d = timeout_ticks_i;
        case (phase_q)
          hlxfp_pkg::PH_HUNT: begin
            phase_d = hunt_next;
          end
          hlxfp_pkg::PH_HDR1: begin
            phase_d = item_i.cls.is_sync1 ? hlxfp_pkg::PH_HDR2 : hunt_next;
          end
          hlxfp_pkg::PH_HDR2: begin
            phase_d = item_i.cls.is_sync2 ? hlxfp_pkg::PH_HDR3 : hunt_next;
          end
          hlxfp_pkg::PH_HDR3: begin
            phase_d = item_i.cls.is_sync3 ? hlxfp_pkg::PH_LEN : hunt_next;
          end
          hlxfp_pkg::PH_LEN: begin
            len_d   = item_i.data;
            phase_d = item_i.cls.is_zero ? hlxfp_pkg::PH_HUNT : hlxfp_pkg::PH_TOKEN;
          end
          hlxfp_pkg::PH_TOKEN: begin
            if (item_i.cls.is_token) begin
              phase_d = hlxfp_pkg::PH_PAYLOAD;
              xor_d   = hlxfp_pkg::SEED_XOR ^ len_q;
              left_d  = len_q;
              pos_d   = 8'd1;
            end else begin
              phase_d = hunt_next;
            end
          end
          hlxfp_pkg::PH_PAYLOAD: begin
            load = 1'b1;
            if (left_q > 8'd1) begin
              // payload byte
              xor_d                   = xor_q ^ item_i.data;
              pos_d                   = pos_q + 8'd1;
              left_d                  = left_q - 8'd1;
              res_d.kind              = hlxfp_pkg::KIND_PAYLOAD;
              res_d.data_byte         = item_i.data;
              res_d.byte_index        = pos_q;
              res_d.frame_length      = len_q;
              res_d.computed_checksum = xor_q ^ item_i.data;
            end else begin
              // checksum byte closes the frame
              left_d                  = 8'd0;
              phase_d                 = hlxfp_pkg::PH_HUNT;
              res_d.kind              = (xor_q == item_i.data) ? hlxfp_pkg::KIND_GOOD
                                                               : hlxfp_pkg::KIND_BAD;
              res_d.data_byte         = item_i.data;
              res_d.byte_index        = 8'd0;
              res_d.frame_length      = len_q;
              res_d.computed_checksum = xor_q;
            end
          end
          default: begin
            phase_d = hlxfp_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  // output register valid
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // parser and output control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hlxfp_pkg::PH_HUNT;
      len_q       <= 8'd0;
      left_q      <= 8'd0;
      xor_q       <= 8'd0;
      pos_q       <= 8'd0;
      cnt_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      left_q      <= left_d;
      xor_q       <= xor_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  `HLXFP_ASSERT(a_frame_end_hunts, clk_i, rst_ni,
                (load && (res_d.kind != hlxfp_pkg::KIND_PAYLOAD)) |=>
                (phase_q == hlxfp_pkg::PH_HUNT))
  `HLXFP_ASSERT(a_timeout_hunts, clk_i, rst_ni,
                (pop && (item_i.opcode == hlxfp_pkg::OP_TICK) && (cnt_q == 8'd1)) |=>
                (phase_q == hlxfp_pkg::PH_HUNT))
  `HLXFP_ASSERT_NEVER(a_payload_index_zero, clk_i, rst_ni,
                      out_valid_q && (res_q.kind == hlxfp_pkg::KIND_PAYLOAD) &&
                      (res_q.byte_index == 8'd0))

endmodule

[hw/rtl/header_length_xor_frame_parser.sv]
// ----------------------------------------------------------------------------
// header_length_xor_frame_parser: sync header / length / xor checksum deframer
// a result passes through the queue entry written at its byte transfer and then
// the output register; throughput one item per cycle while the output is not
// stalled, set by the one-step parser
// reset clears parser state, queue and output valid; timeout returns to 6
// ----------------------------------------------------------------------------
module header_length_xor_frame_parser #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input items
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [7:0] rx_byte_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] byte_index_o,
  output logic [7:0] frame_length_o,
  output logic [7:0] computed_checksum_o,
  // timeout register write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_timeout_ticks_i
);

  logic               item_valid;
  hlxfp_pkg::item_t   item;
  logic               item_pop;
  hlxfp_pkg::result_t result;
  logic [7:0]         timeout_q;

  // timeout register, always ready for a transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= hlxfp_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_timeout_ticks_i;
    end
  end

  // front: accept, classify, queue
  hlxfp_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .rx_byte_i    (rx_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // back: parse and emit results
  hlxfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .timeout_ticks_i (timeout_q),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_pop_o      (item_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_o        (result)
  );

  // result fields
  assign kind_o              = result.kind;
  assign data_byte_o         = result.data_byte;
  assign byte_index_o        = result.byte_index;
  assign frame_length_o      = result.frame_length;
  assign computed_checksum_o = result.computed_checksum;

endmodule

[verif/header_length_xor_frame_parser_tb.sv]
// ----------------------------------------------------------------------------
// header_length_xor_frame_parser_tb
// self-checking bench for the frame parser: feeds bytes and timer ticks,
// tracks the deframer state alongside the block and compares every result
// transfer field by field, under random idling on both sides and a long
// output hold-off, across several timeout settings
// ----------------------------------------------------------------------------
module header_length_xor_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles    = 60;
  localparam int DrainCycles   = 6;
  localparam int DrainLimit    = 300;
  localparam int WatchdogLimit = 1000;
  localparam int MaxPrinted    = 40;
  localparam int IdlePct       = 11;
  localparam int RoundItems    = 8;

  // dut signals
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       opcode = hlxfp_pkg::OP_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [7:0] frame_length;
  logic [7:0] computed_checksum;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_timeout = 8'h00;

  // deframer state tracked by the bench
  hlxfp_pkg::phase_e dfm_phase = hlxfp_pkg::PH_HUNT;
  logic [7:0] dfm_length = 8'h00;
  logic [7:0] dfm_left = 8'h00;
  logic [7:0] dfm_xor = 8'h00;
  logic [7:0] dfm_position = 8'h00;
  logic [7:0] dfm_idle = 8'h00;
  logic [7:0] dfm_timeout = hlxfp_pkg::TIMEOUT_RESET;

  hlxfp_pkg::result_t expected_results[$];
  int         mismatch_count = 0;
  int         items_sent = 0;
  int         quiet_cycles = 0;
  bit         idle_on = 1'b1;
  int         hold_req = 0;
  int         hold_served = 0;
  int         hold_left = 0;

  header_length_xor_frame_parser uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .opcode_i            (opcode),
    .rx_byte_i           (rx_byte),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .kind_o              (kind),
    .data_byte_o         (data_byte),
    .byte_index_o        (byte_index),
    .frame_length_o      (frame_length),
    .computed_checksum_o (computed_checksum),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_timeout_ticks_i (cfg_timeout)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // one mismatch line, printing capped
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // xor over header, length and token
  function automatic logic [7:0] frame_seed(input logic [7:0] len);
    return hlxfp_pkg::SYNC0 ^ hlxfp_pkg::SYNC1 ^ hlxfp_pkg::SYNC2 ^ hlxfp_pkg::SYNC3 ^
           len ^ hlxfp_pkg::TOKEN_CHAR;
  endfunction

  function automatic logic [7:0] sync_byte(input int pos);
    case (pos)
      0: return hlxfp_pkg::SYNC0;
      1: return hlxfp_pkg::SYNC1;
      2: return hlxfp_pkg::SYNC2;
      default: return hlxfp_pkg::SYNC3;
    endcase
  endfunction

  // a mismatching byte may itself open a new header
  function automatic hlxfp_pkg::phase_e restart_phase(input logic [7:0] b);
    return (b == hlxfp_pkg::SYNC0) ? hlxfp_pkg::PH_HDR1 : hlxfp_pkg::PH_HUNT;
  endfunction

  // advance the deframer by one accepted item, queue any result
  function automatic void deframe_step(input logic op, input logic [7:0] b);
    hlxfp_pkg::result_t res;
    if (op == hlxfp_pkg::OP_TICK) begin
      if (dfm_idle != 8'd0) begin
        dfm_idle--;
        if (dfm_idle == 8'd0) begin
          dfm_phase = hlxfp_pkg::PH_HUNT;
        end
      end
    end else begin
      dfm_idle = dfm_timeout;
      case (dfm_phase)
        hlxfp_pkg::PH_HUNT: dfm_phase = restart_phase(b);
        hlxfp_pkg::PH_HDR1:
          dfm_phase = (b == hlxfp_pkg::SYNC1) ? hlxfp_pkg::PH_HDR2 : restart_phase(b);
        hlxfp_pkg::PH_HDR2:
          dfm_phase = (b == hlxfp_pkg::SYNC2) ? hlxfp_pkg::PH_HDR3 : restart_phase(b);
        hlxfp_pkg::PH_HDR3:
          dfm_phase = (b == hlxfp_pkg::SYNC3) ? hlxfp_pkg::PH_LEN : restart_phase(b);
        hlxfp_pkg::PH_LEN: begin
          dfm_length = b;
          dfm_phase = (b == 8'd0) ? hlxfp_pkg::PH_HUNT : hlxfp_pkg::PH_TOKEN;
        end
        hlxfp_pkg::PH_TOKEN: begin
          if (b == hlxfp_pkg::TOKEN_CHAR) begin
            dfm_phase = hlxfp_pkg::PH_PAYLOAD;
            dfm_xor = frame_seed(dfm_length);
            dfm_left = dfm_length;
            dfm_position = 8'd1;
          end else begin
            dfm_phase = restart_phase(b);
          end
        end
        hlxfp_pkg::PH_PAYLOAD: begin
          res.data_byte = b;
          res.frame_length = dfm_length;
          if (dfm_left > 8'd1) begin
            dfm_xor = dfm_xor ^ b;
            res.kind = hlxfp_pkg::KIND_PAYLOAD;
            res.byte_index = dfm_position;
            dfm_position++;
            dfm_left--;
          end else begin
            res.kind = (dfm_xor == b) ? hlxfp_pkg::KIND_GOOD : hlxfp_pkg::KIND_BAD;
            res.byte_index = 8'd0;
            dfm_left = 8'd0;
            dfm_phase = hlxfp_pkg::PH_HUNT;
          end
          res.computed_checksum = dfm_xor;
          expected_results.push_back(res);
        end
        default: dfm_phase = hlxfp_pkg::PH_HUNT;
      endcase
    end
  endfunction

  // one input transfer, with an occasional one-cycle gap ahead of it
  task automatic send_item(input logic op, input logic [7:0] b);
    if (idle_on && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    rx_byte <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
    deframe_step(op, b);
  endtask

  // stop sending, let every expected result arrive, then settle
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      expected_results.delete();
    end
  endtask

  // timeout register write, only while the block is idle
  task automatic write_timeout(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_timeout <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dfm_timeout = value;
  endtask

  // byte preceded now and then by a short tick burst
  task automatic send_frame_byte(input logic [7:0] b, input int tick_pct);
    if ($urandom_range(99) < tick_pct) begin
      repeat ($urandom_range(2, 1)) send_item(hlxfp_pkg::OP_TICK, 8'($urandom));
    end
    send_item(hlxfp_pkg::OP_BYTE, b);
  endtask

  // well-formed frame with random payload
  task automatic send_frame(input logic [7:0] len, input bit good, input int tick_pct);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    sum = frame_seed(len);
    for (i = 0; i < 4; i++) begin
      send_frame_byte(sync_byte(i), tick_pct);
    end
    send_frame_byte(len, tick_pct);
    if (len != 8'd0) begin
      send_frame_byte(hlxfp_pkg::TOKEN_CHAR, tick_pct);
      for (i = 1; i < len; i++) begin
        b = 8'($urandom);
        sum ^= b;
        send_frame_byte(b, tick_pct);
      end
      if (!good) begin
        sum ^= 8'($urandom_range(255, 1));
      end
      send_frame_byte(sum, tick_pct);
    end
  endtask

  // header or token cut short, or an empty frame
  task automatic send_broken();
    int         i;
    int         cut;
    logic [7:0] breaker;
    breaker = ($urandom_range(1) != 0) ? hlxfp_pkg::SYNC0 : 8'($urandom);
    case ($urandom_range(2))
      0: begin
        cut = $urandom_range(3, 1);
        for (i = 0; i < cut; i++) begin
          send_item(hlxfp_pkg::OP_BYTE, sync_byte(i));
        end
        send_item(hlxfp_pkg::OP_BYTE, breaker);
      end
      1: begin
        for (i = 0; i < 4; i++) begin
          send_item(hlxfp_pkg::OP_BYTE, sync_byte(i));
        end
        send_item(hlxfp_pkg::OP_BYTE, 8'($urandom_range(255, 1)));
        send_item(hlxfp_pkg::OP_BYTE, breaker);
      end
      default: begin
        for (i = 0; i < 4; i++) begin
          send_item(hlxfp_pkg::OP_BYTE, sync_byte(i));
        end
        send_item(hlxfp_pkg::OP_BYTE, 8'd0);
      end
    endcase
  endtask

  // header restart, zero length, token restart, short and extreme frames
  task automatic test_directed_cases();
    // tick while the countdown is already zero
    send_item(hlxfp_pkg::OP_TICK, 8'hFF);
    // second sync0 restarts the header, then an empty frame
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC0);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC0);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC1);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC2);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC3);
    send_item(hlxfp_pkg::OP_BYTE, 8'd0);
    // sync0 in place of the token opens a new header
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC0);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC1);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC2);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC3);
    send_item(hlxfp_pkg::OP_BYTE, 8'd1);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC0);
    // length one: checksum straight after the token, wrong value
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC1);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC2);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC3);
    send_item(hlxfp_pkg::OP_BYTE, 8'd1);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::TOKEN_CHAR);
    send_item(hlxfp_pkg::OP_BYTE, ~frame_seed(8'd1));
    // good frame with all-ones and all-zeros payload
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC0);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC1);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC2);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC3);
    send_item(hlxfp_pkg::OP_BYTE, 8'd3);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::TOKEN_CHAR);
    send_item(hlxfp_pkg::OP_BYTE, 8'hFF);
    send_item(hlxfp_pkg::OP_BYTE, 8'h00);
    send_item(hlxfp_pkg::OP_BYTE, frame_seed(8'd3) ^ 8'hFF);
    drain();
  endtask

  // timeout mid-frame, zero timeout never expiring, largest timeout
  task automatic test_timeout_settings();
    write_timeout(8'd2);
    send_frame(8'd3, 1'b1, 0);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC0);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC1);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC2);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC3);
    send_item(hlxfp_pkg::OP_BYTE, 8'd3);
    repeat (3) send_item(hlxfp_pkg::OP_TICK, 8'($urandom));
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::TOKEN_CHAR);
    send_item(hlxfp_pkg::OP_BYTE, 8'h11);
    send_item(hlxfp_pkg::OP_TICK, 8'($urandom));
    send_frame(8'd2, 1'b1, 100);
    drain();
    write_timeout(8'd0);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC0);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC1);
    repeat (12) send_item(hlxfp_pkg::OP_TICK, 8'($urandom));
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC2);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::SYNC3);
    send_item(hlxfp_pkg::OP_BYTE, 8'd1);
    send_item(hlxfp_pkg::OP_BYTE, hlxfp_pkg::TOKEN_CHAR);
    send_item(hlxfp_pkg::OP_BYTE, frame_seed(8'd1));
    drain();
    write_timeout(8'd255);
    send_frame(8'd4, 1'b0, 60);
    drain();
  endtask

  // longest frame, back to back with no idling on either side
  task automatic test_long_frame_no_idling();
    idle_on <= 1'b0;
    send_frame(8'd255, 1'b1, 0);
    send_frame(8'd2, 1'b0, 0);
    drain();
    idle_on <= 1'b1;
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    send_frame(8'd30, 1'b1, 5);
    drain();
  endtask

  // mostly frames with random content, some broken ones and noise
  task automatic test_random_traffic();
    int round;
    int stop_at;
    int pick;
    for (round = 0; round < 4; round++) begin
      case (round)
        0: write_timeout(hlxfp_pkg::TIMEOUT_RESET);
        1: write_timeout(8'd1);
        2: write_timeout(8'($urandom_range(12, 2)));
        default: write_timeout(8'd0);
      endcase
      stop_at = items_sent + RoundItems;
      while (items_sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_frame(($urandom_range(9) == 0) ? 8'($urandom_range(40, 9))
                                              : 8'($urandom_range(8, 1)),
                     $urandom_range(3) != 0, 10);
        end else if (pick < 85) begin
          send_broken();
        end else begin
          repeat ($urandom_range(4, 1)) begin
            send_item(($urandom_range(1) != 0) ? hlxfp_pkg::OP_TICK : hlxfp_pkg::OP_BYTE,
                      8'($urandom));
          end
        end
      end
      drain();
    end
  endtask

  // result checking and output stall generation
  always @(posedge clk) begin : result_check
    hlxfp_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d data %0h", kind, data_byte));
      end else begin
        want = expected_results.pop_front();
        if (kind != want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
        if (data_byte != want.data_byte)
          report_mismatch($sformatf("data_byte got %0h want %0h", data_byte,
                                    want.data_byte));
        if (byte_index != want.byte_index)
          report_mismatch($sformatf("byte_index got %0d want %0d", byte_index,
                                    want.byte_index));
        if (frame_length != want.frame_length)
          report_mismatch($sformatf("frame_length got %0d want %0d", frame_length,
                                    want.frame_length));
        if (computed_checksum != want.computed_checksum)
          report_mismatch($sformatf("computed_checksum got %0h want %0h",
                                    computed_checksum, want.computed_checksum));
      end
    end
    // long hold-off on request, otherwise random stalls
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_req) begin
      hold_served <= hold_req;
      hold_left <= HoldCycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < IdlePct);
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("header_length_xor_frame_parser_tb: errors");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_timeout_settings();
    test_long_frame_no_idling();
    test_backpressure();
    test_random_traffic();
    drain();
    if (mismatch_count == 0) begin
      $display("header_length_xor_frame_parser_tb: clean");
    end else begin
      $display("header_length_xor_frame_parser_tb: errors");
    end
    $finish;
  end

endmodule
